// ----- src/pvp_pkg.sv -----
// Shared types, constants and helpers of the perspective vertex projector.
`default_nettype none
package pvp_pkg;

	localparam int ACC_W = 50;
	localparam int Q_BITS = 40;
	localparam int MAP_W = 53;
	localparam int QUEUE_DEPTH = 4;
	localparam int LANES = 3;

	localparam logic [1:0] REG_ROW0 = 2'd0;
	localparam logic [1:0] REG_ROW1 = 2'd1;
	localparam logic [1:0] REG_ROW2 = 2'd2;
	localparam logic [1:0] REG_ROW3 = 2'd3;

	localparam logic [63:0] ROW0_RESET = 64'h0000_0000_0000_1000;
	localparam logic [63:0] ROW1_RESET = 64'h0000_0000_1000_0000;
	localparam logic [63:0] ROW2_RESET = 64'h0000_1000_0000_0000;
	localparam logic [63:0] ROW3_RESET = 64'h1000_0000_0000_0000;

	// Divisor used when w is zero: dividing the Q.28 sum by 2^28 in Q16.16
	// gives the sum truncated toward zero to Q16.16.
	localparam logic [ACC_W-1:0] DIV_NARROW = ACC_W'(64'd1 << 28);

	localparam logic signed [MAP_W-1:0] SCALE0 = MAP_W'(300);
	localparam logic signed [MAP_W-1:0] OFFSET0 = MAP_W'(500 * 65536);
	localparam logic signed [MAP_W-1:0] SCALE1 = MAP_W'(500);
	localparam logic signed [MAP_W-1:0] ONE_Q16 = MAP_W'(65536);

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic               viewport_mode;
	} in_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic signed [31:0] depth;
		logic               w_was_zero;
	} out_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] acc_x;
		logic signed [ACC_W-1:0] acc_y;
		logic signed [ACC_W-1:0] acc_z;
		logic signed [ACC_W-1:0] acc_w;
		logic                    mode;
	} acc_t;

	function automatic logic signed [31:0] sat32(input logic signed [MAP_W-1:0] v);
		logic signed [31:0] r;
		if (v > MAP_W'(64'sh7FFF_FFFF)) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -MAP_W'(64'sh8000_0000)) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/pvp_front.sv -----
// Front end: accepts points and forms the four matrix column sums.
`default_nettype none
module pvp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [3:0][63:0]  matrix,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire pvp_pkg::in_t      in_data,
	output logic                   push,
	output pvp_pkg::acc_t          push_data,
	input  wire logic              full
);

	logic vld_s1, vld_s2, adv;
	logic signed [47:0] prod_s1 [3][4];
	logic signed [15:0] bias_s1 [4];
	logic mode_s1, mode_s2;
	logic signed [pvp_pkg::ACC_W-1:0] acc_s2 [4];

	assign adv = !vld_s2 || !full;
	assign in_ready = adv;
	assign push = vld_s2 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 4; j++) begin
				prod_s1[0][j] <= 48'(in_data.point_x) * 48'($signed(matrix[0][16*j +: 16]));
				prod_s1[1][j] <= 48'(in_data.point_y) * 48'($signed(matrix[1][16*j +: 16]));
				prod_s1[2][j] <= 48'(in_data.point_z) * 48'($signed(matrix[2][16*j +: 16]));
				bias_s1[j] <= $signed(matrix[3][16*j +: 16]);
				acc_s2[j] <= pvp_pkg::ACC_W'(prod_s1[0][j]) + pvp_pkg::ACC_W'(prod_s1[1][j])
					+ pvp_pkg::ACC_W'(prod_s1[2][j])
					+ pvp_pkg::ACC_W'($signed({bias_s1[j], 16'b0}));
			end
			mode_s1 <= in_data.viewport_mode;
			mode_s2 <= mode_s1;
		end
	end

	always_comb begin
		push_data.acc_x = acc_s2[0];
		push_data.acc_y = acc_s2[1];
		push_data.acc_z = acc_s2[2];
		push_data.acc_w = acc_s2[3];
		push_data.mode  = mode_s2;
	end

endmodule
`default_nettype wire

// ----- src/pvp_queue.sv -----
// Short queue of column sums between the front end and the divide back end.
`default_nettype none
module pvp_queue #(
	parameter int DEPTH = pvp_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire pvp_pkg::acc_t  push_data,
	output logic                full,
	input  wire logic           pop,
	output pvp_pkg::acc_t       head,
	output logic                avail
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pvp_pkg::acc_t mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign avail = (cnt_q != '0);
	assign head = mem[rd_ptr_q];

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (push && !pop) cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

// ----- src/pvp_back.sv -----
// Back end: pipelined restoring divide by w, viewport mapping and output register.
`default_nettype none
module pvp_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pvp_pkg::acc_t  head,
	input  wire logic           avail,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output pvp_pkg::out_t       out_data
);

	localparam int AW = pvp_pkg::ACC_W;
	localparam int QB = pvp_pkg::Q_BITS;
	localparam int NL = pvp_pkg::LANES;
	localparam int MW = pvp_pkg::MAP_W;

	// Stage k of these arrays holds the item after k quotient bits.
	logic          vld_s  [QB+1];
	logic [AW-1:0] rem_s  [QB+1][NL];
	logic [QB-1:0] wq_s   [QB+1][NL];
	logic [AW-1:0] div_s  [QB+1];
	logic          neg_s  [QB+1][NL];
	logic          ovf_s  [QB+1][NL];
	logic          mode_s [QB+1];
	logic          wz_s   [QB+1];

	logic adv, out_vld_q;
	pvp_pkg::out_t out_data_q;

	assign adv = !out_vld_q || out_ready;
	assign pop = adv && avail;
	assign out_valid = out_vld_q;
	assign out_data = out_data_q;

	// Entry stage: magnitudes, signs, overflow test and the first remainder.
	logic signed [AW-1:0] num [NL];
	logic          wz0;
	logic [AW-1:0] d0;
	logic [AW-1:0] n0 [NL];

	always_comb begin
		num[0] = head.acc_x;
		num[1] = head.acc_y;
		num[2] = head.acc_z;
		wz0 = (head.acc_w == '0);
		d0 = wz0 ? pvp_pkg::DIV_NARROW
			: (head.acc_w[AW-1] ? AW'(-head.acc_w) : AW'(head.acc_w));
		for (int l = 0; l < NL; l++) begin
			n0[l] = num[l][AW-1] ? AW'(-num[l]) : AW'(num[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= d0;
			mode_s[0] <= head.mode;
			wz_s[0] <= wz0;
			for (int l = 0; l < NL; l++) begin
				rem_s[0][l] <= AW'(n0[l][AW-1:24]);
				wq_s[0][l] <= {n0[l][23:0], 16'b0};
				neg_s[0][l] <= wz0 ? num[l][AW-1] : (num[l][AW-1] != head.acc_w[AW-1]);
				ovf_s[0][l] <= !wz0 && ({24'b0, n0[l]} >= {d0, 24'b0});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= avail;
			for (int k = 1; k <= QB; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// One quotient bit per stage for each of the three lanes.
	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [AW:0]   trial [NL];
		logic          ge    [NL];
		logic [AW-1:0] rnext [NL];

		always_comb begin
			for (int l = 0; l < NL; l++) begin
				trial[l] = {rem_s[k][l], wq_s[k][l][QB-1]};
				ge[l] = (trial[l] >= {1'b0, div_s[k]});
				rnext[l] = ge[l] ? AW'(trial[l] - {1'b0, div_s[k]}) : trial[l][AW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k+1] <= div_s[k];
				mode_s[k+1] <= mode_s[k];
				wz_s[k+1] <= wz_s[k];
				for (int l = 0; l < NL; l++) begin
					rem_s[k+1][l] <= rnext[l];
					wq_s[k+1][l] <= {wq_s[k][l][QB-2:0], ge[l]};
					neg_s[k+1][l] <= neg_s[k][l];
					ovf_s[k+1][l] <= ovf_s[k][l];
				end
			end
		end
	end

	// Signed quotients, clamped at 2^40, then the viewport mapping.
	logic [QB:0] mag [NL];
	logic signed [MW-1:0] v [NL];
	logic signed [MW-1:0] sx, sy;

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			mag[l] = ovf_s[QB][l] ? {1'b1, {QB{1'b0}}} : {1'b0, wq_s[QB][l]};
			v[l] = neg_s[QB][l] ? -$signed(MW'(mag[l])) : $signed(MW'(mag[l]));
		end
		if (!mode_s[QB]) begin
			sx = v[0] * pvp_pkg::SCALE0 + pvp_pkg::OFFSET0;
			sy = v[1] * pvp_pkg::SCALE0;
		end else begin
			sx = (v[0] + pvp_pkg::ONE_Q16) * pvp_pkg::SCALE1;
			sy = (v[1] + pvp_pkg::ONE_Q16) * pvp_pkg::SCALE1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q.screen_x <= pvp_pkg::sat32(sx);
			out_data_q.screen_y <= pvp_pkg::sat32(sy);
			out_data_q.depth <= pvp_pkg::sat32(v[2]);
			out_data_q.w_was_zero <= wz_s[QB];
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !out_ready |=> $stable(vld_s[QB]) && $stable(vld_s[0]))
		else $error("divide pipeline moved while the output was stalled");

	a_zero_w_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QB] && wz_s[QB] |-> div_s[QB] == pvp_pkg::DIV_NARROW)
		else $error("zero w item without the narrowing divisor");

	a_zero_w_no_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] && wz_s[0] |-> !ovf_s[0][0] && !ovf_s[0][1] && !ovf_s[0][2])
		else $error("clamp flagged on a zero w item");

	a_pop_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> vld_s[0])
		else $error("popped sum did not enter the divide pipeline");

endmodule
`default_nettype wire

// ----- src/perspective_vertex_projector_unit.sv -----
// Top level of the perspective vertex projector: matrix registers and the two halves.
`default_nettype none
// Usage: a point (Q16.16 x, y, z and a viewport mode) is offered on in_valid/in_data
// and is transferred when in_ready is high too. One result per point leaves on
// out_valid/out_data and is transferred when out_ready is high.
// The matrix is loaded through cfg_we/cfg_index/cfg_data, one 64-bit row per
// write; the user must do so only while no point is in flight, which the block
// itself does not enforce. Reset loads the identity matrix and empties the
// pipeline and the queue. When nothing stalls, throughput is one point per cycle.
// The result of a point passes through two front stages of products and sums,
// the queue, one entry stage of the divider, forty stages of a restoring divide
// (one quotient bit each) and the output register, where the viewport mapping
// is folded in.
// When the receiver stalls, the output register and the divide pipeline hold;
// the front end keeps taking points until the queue between the two is full,
// and then in_ready falls.
module perspective_vertex_projector_unit #(
	parameter int QUEUE_DEPTH = pvp_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire pvp_pkg::in_t   in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output pvp_pkg::out_t       out_data,
	input  wire logic           cfg_we,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [63:0]    cfg_data
);

	logic [3:0][63:0] matrix_q;
	logic push, full, pop, avail;
	pvp_pkg::acc_t push_data, head;

	// Matrix rows; every index of the two-bit port names a row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q[0] <= pvp_pkg::ROW0_RESET;
			matrix_q[1] <= pvp_pkg::ROW1_RESET;
			matrix_q[2] <= pvp_pkg::ROW2_RESET;
			matrix_q[3] <= pvp_pkg::ROW3_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pvp_pkg::REG_ROW0: matrix_q[0] <= cfg_data;
				pvp_pkg::REG_ROW1: matrix_q[1] <= cfg_data;
				pvp_pkg::REG_ROW2: matrix_q[2] <= cfg_data;
				pvp_pkg::REG_ROW3: matrix_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front end computes the Q.28 column sums and pushes them into the queue.
	pvp_front u_front (
		.clk(clk), .arst_n(arst_n), .matrix(matrix_q),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.push(push), .push_data(push_data), .full(full)
	);

	pvp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data), .full(full),
		.pop(pop), .head(head), .avail(avail)
	);

	// The back end divides by w, maps to the viewport and saturates.
	pvp_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .avail(avail), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule
`default_nettype wire

// ----- tb/sv/perspective_vertex_projector_unit_test.sv -----
// Self-checking testbench of the perspective vertex projector unit.
`timescale 1ns / 100ps
module perspective_vertex_projector_unit_test;

	// The drain margin exceeds the latency when nothing stalls, so it is safe.
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_POINTS = 950;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	pvp_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	pvp_pkg::out_t out_data;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [63:0] cfg_data;

	perspective_vertex_projector_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// The model's own copy of the matrix, updated whenever a row is written.
	logic [63:0] model_rows [4];

	// Points waiting to be offered and projections waiting to come out.
	pvp_pkg::in_t pending_points [$];
	pvp_pkg::out_t expected_projections [$];

	int mismatch_count;
	int cycle_count;
	int long_stall_count;
	bit long_stall_request;
	bit in_accepted;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Signed Q4.12 entry of the model matrix.
	function automatic longint matrix_entry(int row, int col);
		logic [15:0] raw;
		raw = model_rows[row][16*col +: 16];
		return longint'($signed(raw));
	endfunction

	// Magnitude-based divide of two equally formatted values into Q16.16, truncated and
	// clamped at 2^40 when the integer part does not fit in 24 bits.
	function automatic longint divide_to_q16(longint num, longint den);
		longint unsigned n, d, whole, rest, frac, q;
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		whole = n / d;
		rest = n % d;
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			rest = rest << 1;
			frac = frac << 1;
			if (rest >= d) begin
				rest = rest - d;
				frac = frac | 1;
			end
		end
		q = (whole >= (64'd1 << 24)) ? (64'd1 << 40) : ((whole << 16) | frac);
		return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
	endfunction

	// Truncates a Q.28 sum toward zero into Q16.16.
	function automatic longint narrow_to_q16(longint v);
		longint unsigned m;
		m = (v < 0) ? -v : v;
		m = m >> 12;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sh7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		if (v < -64'sh8000_0000)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// Projects one point through the model matrix and the selected viewport mapping.
	function automatic pvp_pkg::out_t predict_projection(pvp_pkg::in_t p);
		longint sums [4];
		longint vx, vy, vz, sx, sy;
		pvp_pkg::out_t r;
		for (int j = 0; j < 4; j++) begin
			sums[j] = longint'(p.point_x) * matrix_entry(0, j)
				+ longint'(p.point_y) * matrix_entry(1, j)
				+ longint'(p.point_z) * matrix_entry(2, j)
				+ matrix_entry(3, j) * 65536;
		end
		r.w_was_zero = (sums[3] == 0);
		if (r.w_was_zero) begin
			vx = narrow_to_q16(sums[0]);
			vy = narrow_to_q16(sums[1]);
			vz = narrow_to_q16(sums[2]);
		end else begin
			vx = divide_to_q16(sums[0], sums[3]);
			vy = divide_to_q16(sums[1], sums[3]);
			vz = divide_to_q16(sums[2], sums[3]);
		end
		if (p.viewport_mode == 1'b0) begin
			sx = vx * 300 + 500 * 65536;
			sy = vy * 300;
		end else begin
			sx = (vx + 65536) * 500;
			sy = (vy + 65536) * 500;
		end
		r.screen_x = clamp32(sx);
		r.screen_y = clamp32(sy);
		r.depth = clamp32(vz);
		return r;
	endfunction

	// Coordinates favor small values so that the divide produces meaningful quotients,
	// with occasional extremes and fully random words.
	function automatic logic [31:0] random_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 20 * 65536))) - 32'sd10 * 65536;
		endcase
	endfunction

	function automatic logic [15:0] random_entry();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 16'h0000;
			default: return 16'($signed($urandom_range(0, 8192))) - 16'sd4096;
		endcase
	endfunction

	function automatic pvp_pkg::in_t make_point(logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic mode);
		pvp_pkg::in_t p;
		p.point_x = x;
		p.point_y = y;
		p.point_z = z;
		p.viewport_mode = mode;
		return p;
	endfunction

	// Driver: offers pending points in bursts with random gaps. A point stays on the bus
	// until the rising edge of its transfer, which the input sampler reports, and valid
	// is only ever assigned once per falling edge.
	int burst_left;
	int gap_left;
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_accepted) begin
			// Hold the offered point until it is transferred.
		end else begin
			in_accepted = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_points.size() > 0) begin
				in_data <= pending_points[0];
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern, with one long hold-off that fills the internal queue.
	int stall_phase;
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_phase = 0;
		end else if (long_stall_request) begin
			out_ready <= 1'b0;
			long_stall_count++;
		end else begin
			stall_phase = (stall_phase + 1) % 200;
			if (stall_phase < 60)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// Monitor: checks each transferred result against the oldest expected projection.
	always @(posedge clk) begin
		pvp_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_projections.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected result transfer: %p", out_data);
			end else begin
				want = expected_projections.pop_front();
				if (out_data.screen_x !== want.screen_x || out_data.screen_y !== want.screen_y
						|| out_data.depth !== want.depth
						|| out_data.w_was_zero !== want.w_was_zero) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Mismatch: expected x=%h y=%h depth=%h wz=%b, got x=%h y=%h depth=%h wz=%b",
							want.screen_x, want.screen_y, want.depth, want.w_was_zero,
							out_data.screen_x, out_data.screen_y, out_data.depth,
							out_data.w_was_zero);
				end
			end
		end
	end

	// Expected results are computed when a point is transferred into the block; the
	// transferred point leaves the pending queue at the same edge.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			expected_projections.push_back(predict_projection(in_data));
			void'(pending_points.pop_front());
			in_accepted = 1'b1;
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_row(logic [1:0] index, logic [63:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		model_rows[index] = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every point has been transferred and every projection has come out.
	task automatic wait_idle();
		while (pending_points.size() > 0 || in_valid || expected_projections.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_random_matrix(int style);
		logic [63:0] row;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				case (style)
					0: row[16*c +: 16] = random_entry();
					1: row[16*c +: 16] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
					default: row[16*c +: 16] = (r == c) ? 16'h1000 : 16'h0000;
				endcase
			end
			// A w column of zero in rows 0-2 and row 3 forces w to zero for every point.
			if (style == 3)
				row[63:48] = 16'h0000;
			write_row(pvp_pkg::REG_ROW0 + 2'(r), row);
		end
	endtask

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = pvp_pkg::REG_ROW0;
		cfg_data = '0;
		arst_n = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		long_stall_count = 0;
		long_stall_request = 1'b0;
		in_accepted = 1'b0;
		burst_left = 0;
		gap_left = 0;
		model_rows[0] = pvp_pkg::ROW0_RESET;
		model_rows[1] = pvp_pkg::ROW1_RESET;
		model_rows[2] = pvp_pkg::ROW2_RESET;
		model_rows[3] = pvp_pkg::ROW3_RESET;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed points on the reset identity matrix, where w is always 1.0.
		pending_points.push_back(make_point(32'h0, 32'h0, 32'h0, 1'b0));
		pending_points.push_back(make_point(32'h0, 32'h0, 32'h0, 1'b1));
		pending_points.push_back(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
		pending_points.push_back(make_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
		pending_points.push_back(make_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b0));
		pending_points.push_back(make_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1));
		wait_idle();

		// Perspective matrix: w = -z, so z of zero skips the divide, small z gives huge
		// quotients that saturate, and the sign of w flips with z.
		write_row(pvp_pkg::REG_ROW0, 64'h0000_0000_0000_1000);
		write_row(pvp_pkg::REG_ROW1, 64'h0000_0000_1000_0000);
		write_row(pvp_pkg::REG_ROW2, 64'hF000_E000_0000_0000);
		write_row(pvp_pkg::REG_ROW3, 64'h0000_F000_0000_0000);
		pending_points.push_back(make_point(32'h0002_0000, 32'h0001_0000, 32'h0, 1'b0));
		pending_points.push_back(make_point(32'h0002_0000, 32'hFFFF_0000, 32'h0, 1'b1));
		pending_points.push_back(make_point(32'h0002_0000, 32'h0001_0000, 32'hFFFE_0000, 1'b0));
		pending_points.push_back(make_point(32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 1'b1));
		pending_points.push_back(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0));
		pending_points.push_back(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		pending_points.push_back(make_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
		wait_idle();

		// Extreme matrix entries, then an all-zero w column.
		load_random_matrix(1);
		pending_points.push_back(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
		pending_points.push_back(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
		pending_points.push_back(make_point(32'h0001_0000, 32'h0, 32'hFFFF_0000, 1'b0));
		wait_idle();
		load_random_matrix(3);
		pending_points.push_back(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1'b0));
		pending_points.push_back(make_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b1));
		wait_idle();

		// Random phases, each on its own matrix.
		for (int phase = 0; phase < 10; phase++) begin
			load_random_matrix((phase % 4 == 3) ? 3 : (phase == 5 ? 1 : 0));
			for (int k = 0; k < RANDOM_POINTS / 10; k++)
				pending_points.push_back(make_point(random_coord(), random_coord(),
					random_coord(), 1'($urandom_range(0, 1))));
			if (phase == 2) begin
				// Hold the receiver off while the sender keeps offering points.
				@(negedge clk);
				long_stall_count = 0;
				long_stall_request = 1'b1;
				while (long_stall_count < 300)
					@(negedge clk);
				long_stall_request = 1'b0;
			end
			wait_idle();
		end

		if (mismatch_count == 0 && expected_projections.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/pvp_pkg.sv
src/pvp_front.sv
src/pvp_queue.sv
src/pvp_back.sv
src/perspective_vertex_projector_unit.sv
tb/sv/perspective_vertex_projector_unit_test.sv
